// ===== design/spectrum_bin_colormap_unit_defines.svh =====
// assertion macros used by the checker of the spectrum colormap block
`ifndef SPECTRUM_BIN_COLORMAP_UNIT_DEFINES_SVH
`define SPECTRUM_BIN_COLORMAP_UNIT_DEFINES_SVH

// same-cycle implication
`define SBC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/sbc_pkg.sv =====
package sbc_pkg;

   localparam int SAMPLE_WIDTH = 32;

   localparam logic [1:0] MODE_GRAY   = 2'd0;
   localparam logic [1:0] MODE_HUE    = 2'd1;
   localparam logic [1:0] MODE_LINEAR = 2'd2;

   localparam logic [1:0] REG_COLOR_MODE  = 2'd0;
   localparam logic [1:0] REG_LOG_GAIN    = 2'd1;
   localparam logic [1:0] REG_LOG_OFFSET  = 2'd2;
   localparam logic [1:0] REG_LINEAR_GAIN = 2'd3;

   localparam logic [18:0] LOG10_2_Q20 = 19'd315653;
   localparam logic [63:0] LEVEL_ROUND = (64'd1 << 40) + (64'd1 << 23);

   localparam logic signed [16:0] LEVEL_RESET_LOW = 17'sd65535;
   localparam logic signed [23:0] CODE_LIMIT      = 24'sd8388607;

endpackage

// ===== design/spectrum_bin_colormap_unit.sv =====
// Spectrum bin colormap: one complex bin (signed Q15.16 real and imaginary) in, one RGB
// pixel out, along with running extremes of the log10 level and of the pre-clamp code.
// Everything runs on one shared 33x33 signed multiplier plus a restoring square-root
// step, under a small sequencer, and the block takes one bin at a time. A bin passes
// through 2 squares, 32 root steps, 1 gain multiply and 1 finish in linear mode, and
// the log modes add 5 normalize steps, 16 log squarings and 1 level multiply; the next
// bin is taken in the idle step. The 32-step root and the 16 log2 squarings on the
// shared multiplier set how long a bin takes. A pixel that is not taken holds the
// sequencer in its finish step. A new bin is taken as soon as the sequencer is idle,
// even while the previous pixel still waits to be taken. Configuration registers are
// written through the csr port and must only change while the block is idle.
module spectrum_bin_colormap_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_real_part,
   input  logic [31:0] req_imag_part,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic signed [16:0] rsp_level_max,
   output logic signed [16:0] rsp_level_min,
   output logic signed [23:0] rsp_code_max,
   output logic signed [23:0] rsp_code_min
);
   import sbc_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SQA   = 4'd1;
   localparam logic [3:0] ST_SQB   = 4'd2;
   localparam logic [3:0] ST_ROOT  = 4'd3;
   localparam logic [3:0] ST_NORM  = 4'd4;
   localparam logic [3:0] ST_LOGSQ = 4'd5;
   localparam logic [3:0] ST_LEVEL = 4'd6;
   localparam logic [3:0] ST_CODE  = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;

   // configuration
   logic [1:0]         mode_ff;
   logic [7:0]         log_gain_ff;
   logic signed [10:0] log_offset_ff;
   logic [7:0]         lin_gain_ff;

   // sequencer and datapath
   logic [3:0]  state_ff;
   logic [4:0]  cnt_ff;
   logic [31:0] ar_ff, ai_ff;
   logic [63:0] rad_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;
   logic [31:0] m_ff;
   logic [4:0]  exp_ff;
   logic [15:0] frac_ff;
   logic signed [16:0] level_ff;
   logic signed [40:0] prod_ff;

   // tracked extremes
   logic signed [16:0] level_high_ff, level_low_ff;
   logic signed [23:0] code_high_ff, code_low_ff;

   // output stage
   logic       rsp_valid_ff;
   logic [7:0] red_ff, green_ff, blue_ff;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;

   logic signed [31:0] re_s, im_s;
   logic [31:0] ar_in, ai_in;

   // root step
   logic [35:0] rem_sh, trial;
   logic        root_ge;
   logic [33:0] rem_in;
   logic [31:0] root_in;

   // normalize step
   logic [4:0]  shamt;
   logic [31:0] top_mask;
   logic        norm_zero;

   // log squaring step
   logic [32:0] sq;
   logic signed [20:0] l2;
   logic [63:0] lvl_sum;
   logic [17:0] lvl_shift;
   logic signed [16:0] level_in;

   // finish
   logic signed [40:0] t_neg, code_wide;
   logic signed [23:0] code_in;
   logic signed [17:0] hue;
   logic [14:0] hue_c;
   logic [16:0] hue6;
   logic [2:0]  sector;
   logic [13:0] frac_h;
   logic [14:0] frac_dn;
   logic [21:0] up_w;
   logic [22:0] dn_w;
   logic [7:0]  up, dn;
   logic signed [24:0] gray_w;
   logic [7:0]  red_in, green_in, blue_in;
   logic        fin_go;

   assign re_s  = 32'($signed(req_real_part[SAMPLE_WIDTH-1:0]));
   assign im_s  = 32'($signed(req_imag_part[SAMPLE_WIDTH-1:0]));
   assign ar_in = re_s[31] ? 32'(-re_s) : re_s;
   assign ai_in = im_s[31] ? 32'(-im_s) : im_s;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQA: begin
            mul_a = {1'b0, ar_ff};
            mul_b = {1'b0, ar_ff};
         end
         ST_SQB: begin
            mul_a = {1'b0, ai_ff};
            mul_b = {1'b0, ai_ff};
         end
         ST_LOGSQ: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, m_ff};
         end
         ST_LEVEL: begin
            mul_a = 33'(l2);
            mul_b = {14'd0, LOG10_2_Q20};
         end
         ST_CODE: begin
            if (mode_ff == MODE_LINEAR) begin
               mul_a = {1'b0, root_ff};
               mul_b = {25'd0, lin_gain_ff};
            end else begin
               mul_a = 33'(level_ff);
               mul_b = {25'd0, log_gain_ff};
            end
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // one restoring square-root step, two radicand bits in
   assign rem_sh  = {rem_ff, rad_ff[63:62]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign root_ge = rem_sh >= trial;
   assign rem_in  = root_ge ? 34'(rem_sh - trial) : rem_sh[33:0];
   assign root_in = {root_ff[30:0], root_ge};

   // binary normalize: shift by 16, 8, 4, 2, 1
   assign shamt     = 5'(5'd1 << cnt_ff[2:0]);
   assign top_mask  = ~(32'hFFFF_FFFF >> shamt);
   assign norm_zero = (m_ff & top_mask) == '0;

   // log2 squaring, level scaling
   assign sq        = mul_p[63:31];
   assign l2        = {exp_ff ^ 5'b10000, frac_ff};
   assign lvl_sum   = 64'(mul_p) + LEVEL_ROUND;
   assign lvl_shift = 18'(lvl_sum >> 24) - 18'd65536;
   assign level_in  = lvl_shift[16:0];

   // finish: code, pixel
   assign t_neg   = -prod_ff;
   assign hue     = 18'(level_ff) + 18'sd16384;
   assign hue_c   = hue[17] ? 15'd0 : (hue > 18'sd16384 ? 15'd16384 : hue[14:0]);
   assign hue6    = (17'(hue_c) << 2) + (17'(hue_c) << 1);
   assign sector  = hue6[16:14];
   assign frac_h  = hue6[13:0];
   assign frac_dn = 15'd16384 - 15'(frac_h);
   assign up_w    = (22'(frac_h) << 8) - 22'(frac_h);
   assign dn_w    = (23'(frac_dn) << 8) - 23'(frac_dn);
   assign up      = up_w[21:14];
   assign dn      = dn_w[21:14];

   always_comb begin
      code_wide = '0;
      red_in    = '0;
      green_in  = '0;
      blue_in   = '0;
      gray_w    = '0;
      if (mode_ff == MODE_LINEAR) begin
         // saturate the scaled magnitude before it is tracked
         code_wide = prod_ff[39] ? 41'(CODE_LIMIT) : 41'(prod_ff[39:16]);
         red_in    = (code_wide > 41'sd255) ? 8'd255 : code_wide[7:0];
         blue_in   = red_in;
      end else if (mode_ff == MODE_HUE) begin
         code_wide = hue[17] ? -41'(18'(-hue) >> 14) : 41'(hue >>> 14);
         case (sector)
            3'd0: begin red_in = 8'd255; green_in = up;     blue_in = 8'd0;   end
            3'd1: begin red_in = dn;     green_in = 8'd255; blue_in = 8'd0;   end
            3'd2: begin red_in = 8'd0;   green_in = 8'd255; blue_in = up;     end
            3'd3: begin red_in = 8'd0;   green_in = dn;     blue_in = 8'd255; end
            3'd4: begin red_in = up;     green_in = 8'd0;   blue_in = 8'd255; end
            3'd5: begin red_in = 8'd255; green_in = 8'd0;   blue_in = dn;     end
            default: begin red_in = 8'd0; green_in = 8'd0; blue_in = 8'd0;   end
         endcase
      end else begin
         // truncate toward zero
         code_wide = prod_ff[40] ? -(t_neg >>> 12) : (prod_ff >>> 12);
         gray_w    = 25'sd255 - 25'(code_wide);
         red_in    = gray_w[24] ? 8'd0 : (gray_w > 25'sd255 ? 8'd255 : gray_w[7:0]);
         green_in  = red_in;
         blue_in   = red_in;
      end
   end

   assign code_in = code_wide[23:0];
   assign fin_go  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ready);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_GRAY;
         log_gain_ff   <= 8'd85;
         log_offset_ff <= 11'sd200;
         lin_gain_ff   <= 8'd100;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_COLOR_MODE:  mode_ff       <= csr_wdata[1:0];
            REG_LOG_GAIN:    log_gain_ff   <= csr_wdata[7:0];
            REG_LOG_OFFSET:  log_offset_ff <= csr_wdata;
            REG_LINEAR_GAIN: lin_gain_ff   <= csr_wdata[7:0];
            default:         mode_ff       <= mode_ff;
         endcase
      end
   end

   // sequencer and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         level_high_ff <= '0;
         level_low_ff  <= LEVEL_RESET_LOW;
         code_high_ff  <= '0;
         code_low_ff   <= CODE_LIMIT;
      end else begin
         // a pixel taken in the cycle a new one is loaded keeps valid high
         if (rsp_valid_ff && rsp_ready && !fin_go)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid)
                  state_ff <= ST_SQA;
            end
            ST_SQA: state_ff <= ST_SQB;
            ST_SQB: begin
               cnt_ff   <= 5'd31;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (cnt_ff == '0) begin
                  if (mode_ff == MODE_LINEAR) begin
                     state_ff <= ST_CODE;
                  end else begin
                     cnt_ff   <= 5'd4;
                     state_ff <= ST_NORM;
                  end
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
            ST_NORM: begin
               if (cnt_ff == '0) begin
                  cnt_ff   <= 5'd15;
                  state_ff <= ST_LOGSQ;
               end else begin
                  cnt_ff <= cnt_ff - 5'd1;
               end
            end
            ST_LOGSQ: begin
               cnt_ff <= cnt_ff - 5'd1;
               if (cnt_ff == '0)
                  state_ff <= ST_LEVEL;
            end
            ST_LEVEL: state_ff <= ST_CODE;
            ST_CODE:  state_ff <= ST_FIN;
            ST_FIN: begin
               if (fin_go) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
                  if (mode_ff != MODE_LINEAR) begin
                     if (level_ff > level_high_ff) level_high_ff <= level_ff;
                     if (level_ff < level_low_ff)  level_low_ff  <= level_ff;
                  end
                  if (code_in > code_high_ff) code_high_ff <= code_in;
                  if (code_in < code_low_ff)  code_low_ff  <= code_in;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            ar_ff <= ar_in;
            ai_ff <= ai_in;
         end
         ST_SQA: rad_ff <= mul_p[63:0];
         ST_SQB: begin
            rad_ff  <= rad_ff + mul_p[63:0];
            rem_ff  <= '0;
            root_ff <= '0;
         end
         ST_ROOT: begin
            rad_ff  <= rad_ff << 2;
            rem_ff  <= rem_in;
            root_ff <= root_in;
            // zero magnitude takes the level of one lsb
            m_ff    <= (root_in == '0) ? 32'd1 : root_in;
            exp_ff  <= 5'd31;
            frac_ff <= '0;
         end
         ST_NORM: begin
            if (norm_zero) begin
               m_ff   <= m_ff << shamt;
               exp_ff <= exp_ff - shamt;
            end
         end
         ST_LOGSQ: begin
            frac_ff <= {frac_ff[14:0], sq[32]};
            m_ff    <= sq[32] ? sq[32:1] : sq[31:0];
         end
         ST_LEVEL: level_ff <= level_in;
         ST_CODE: begin
            if (mode_ff == MODE_LINEAR)
               prod_ff <= {1'b0, mul_p[39:0]};
            else
               prod_ff <= 41'(mul_p) + (41'(log_offset_ff) <<< 12);
         end
         ST_FIN: begin
            if (fin_go) begin
               red_ff   <= red_in;
               green_ff <= green_in;
               blue_ff  <= blue_in;
            end
         end
         default: rad_ff <= rad_ff;
      endcase
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_level_max = level_high_ff;
   assign rsp_level_min = level_low_ff;
   assign rsp_code_max  = code_high_ff;
   assign rsp_code_min  = code_low_ff;

endmodule

// ===== design/sbc_checker.sv =====
`include "spectrum_bin_colormap_unit_defines.svh"

module sbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic signed [23:0] rsp_code_max
);
   // busy right after a transfer in
   `SBC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)
   // no pixel the cycle after a transfer in
   `SBC_ASSERT_IMPLY(a_no_instant_rsp, clock, reset, $rose(rsp_valid), !$past(req_valid && req_ready))
   // result holds until taken
   `SBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // running code maximum never falls
   `SBC_ASSERT_IMPLY(a_code_max_mono, clock, reset, !$past(reset), rsp_code_max >= $past(rsp_code_max))

endmodule

bind spectrum_bin_colormap_unit sbc_checker u_sbc_checker (.*);
